>>> hdl/chunked_bump_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef CHUNKED_BUMP_ALLOCATOR_DEFINES_SVH
`define CHUNKED_BUMP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define CBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define CBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/cba_pkg.sv
`default_nettype none

package cba_pkg;

    // Fixed field widths
    localparam int unsigned BYTE_W  = 25;   // byte counts up to the region size
    localparam int unsigned ADDR_W  = 24;   // byte offset in the region
    localparam int unsigned REQ_W   = 32;   // count * elem_bytes
    localparam int unsigned WIDE_W  = 34;   // fill + padding + request
    localparam int unsigned CUR_W   = 26;   // chunk start + fill
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned SIZE_W  = 33;   // request + alignment

    localparam int unsigned DEF_MAX_CHUNKS  = 8;
    localparam longint unsigned REGION_BYTES = 64'd16777216;
    localparam int unsigned MAX_ALIGN_LOG2  = 12;
    localparam int unsigned MIN_ALIGN_LOG2  = 4;
    localparam int unsigned ALW             = MAX_ALIGN_LOG2;
    localparam int unsigned RESET_CHUNK_SIZE = 64 * 1024;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_RESET = 2'd1,
        KIND_FINAL = 2'd2,
        KIND_NOP   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK_OLD = 3'd0,
        ST_OK_NEW = 3'd1,
        ST_ZERO   = 3'd2,
        ST_FULL   = 3'd3,
        ST_DONE   = 3'd4
    } t_status;

    typedef struct packed {
        logic              fits;
        logic [ALW-1:0]    pad;
        logic [CUR_W-1:0]  al;
        logic [WIDE_W-1:0] need;
        logic [WIDE_W-1:0] new_fill;
    } t_fit_res;

endpackage

`default_nettype wire

>>> hdl/cba_ram.sv
`default_nettype none

module cba_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/cba_fit.sv
`default_nettype none

// Fit unit: padding of a chunk's bump pointer, then the first-fit test.
module cba_fit (
    input  wire logic [cba_pkg::ADDR_W-1:0] i_start,
    input  wire logic [cba_pkg::BYTE_W-1:0] i_fill,
    input  wire logic [cba_pkg::BYTE_W-1:0] i_bytes,
    input  wire logic [cba_pkg::ALW-1:0]    i_mask,
    input  wire logic [cba_pkg::ALW-1:0]    i_pad,
    input  wire logic [cba_pkg::REQ_W-1:0]  i_req,
    output cba_pkg::t_fit_res               o_res
);

    logic [cba_pkg::CUR_W-1:0] w_cur;
    logic [cba_pkg::ALW-1:0]   w_pad;

    always_comb begin
        w_cur = cba_pkg::CUR_W'(i_start) + cba_pkg::CUR_W'(i_fill);
        // distance up to the next aligned byte: two's complement of the low bits
        w_pad = (~w_cur[cba_pkg::ALW-1:0] + cba_pkg::ALW'(1)) & i_mask;
        o_res.pad      = w_pad;
        o_res.al       = w_cur + cba_pkg::CUR_W'(w_pad);
        o_res.need     = cba_pkg::WIDE_W'(i_req) + cba_pkg::WIDE_W'(i_pad);
        o_res.new_fill = cba_pkg::WIDE_W'(i_fill) + o_res.need;
        o_res.fits     = (o_res.new_fill <= cba_pkg::WIDE_W'(i_bytes));
    end

endmodule

`default_nettype wire

>>> hdl/chunked_bump_allocator.sv
// Channel   Direction  Handshake                        Payload
// s_axis    in         s_axis_tvalid / s_axis_tready    tuser: kind; tdata: request
// m_axis    out        m_axis_tvalid / m_axis_tready    tuser: status; tdata: result
// cfg       in         i_cfg_we (no back-pressure)      i_cfg_wdata: default chunk size
//
// An allocate item either lands in an open chunk after trying the ones before it,
// opens a chunk once every open chunk has missed, or runs out of space; each chunk
// tried costs a read, a pad and a fit step through the one fit unit.
// A reset item sweeps the fill table, one open chunk a cycle; finalize,
// unused-kind and zero-size items go from the idle step straight to the reply step.
// i_rst_n is synchronous; chunk tables are not cleared, entries beyond the
// open count are never read. A stalled m_axis holds the block in its reply
// step; the next item can be taken while the last result still waits.
`default_nettype none

`include "chunked_bump_allocator_defines.svh"

module chunked_bump_allocator #(
    parameter int unsigned MAX_CHUNKS = cba_pkg::DEF_MAX_CHUNKS
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration: default_chunk_size
    input  wire logic         i_cfg_we,
    input  wire logic [24:0]  i_cfg_wdata,
    // request item
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [39:0]  s_axis_tdata,  // count[15:0], elem_bytes[31:16],
                                             // align_log2[35:32], zero[39:36]
    input  wire logic [1:0]   s_axis_tuser,  // kind[1:0]
    // result item
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [111:0]      m_axis_tdata,  // address[23:0], chunk_index[26:24],
                                             // total_bytes[51:27], peak_bytes[76:52],
                                             // alloc_total[108:77], zero[111:109]
    output logic [2:0]        m_axis_tuser   // status[2:0]
);

    localparam int unsigned IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);
    localparam int unsigned GEO_W = cba_pkg::BYTE_W + cba_pkg::ADDR_W;
    localparam int unsigned BW = cba_pkg::BYTE_W;
    localparam int unsigned ALW = cba_pkg::ALW;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_MUL  = 10'b00_0000_0010,
        S_RD   = 10'b00_0000_0100,
        S_PAD  = 10'b00_0000_1000,
        S_FIT  = 10'b00_0001_0000,
        S_NEWC = 10'b00_0010_0000,
        S_NEWF = 10'b00_0100_0000,
        S_STAT = 10'b00_1000_0000,
        S_CLR  = 10'b01_0000_0000,
        S_RESP = 10'b10_0000_0000
    } t_state;

    // control registers
    t_state                   r_state, n_state;
    logic                     r_out_valid, n_out_valid;
    logic [CW-1:0]            r_open, n_open;
    logic [BW-1:0]            r_top, n_top;
    logic [BW-1:0]            r_reserved, n_reserved;
    logic [BW-1:0]            r_used, n_used;
    logic [BW-1:0]            r_peak, n_peak;
    logic [cba_pkg::CNT_W-1:0] r_alloc, n_alloc;
    logic [BW-1:0]            r_dflt, n_dflt;

    // payload registers
    logic [15:0]               r_count, n_count;
    logic [15:0]               r_isize, n_isize;
    logic [ALW-1:0]            r_mask, n_mask;
    logic [cba_pkg::REQ_W-1:0] r_req, n_req;
    logic [CW-1:0]             r_idx, n_idx;
    logic [ALW-1:0]            r_pad, n_pad;
    logic [cba_pkg::CUR_W-1:0] r_al, n_al;
    logic [BW-1:0]             r_base, n_base;
    logic [cba_pkg::SIZE_W-1:0] r_size, n_size;
    cba_pkg::t_status          r_status, n_status;
    logic [cba_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic                      r_success, n_success;
    logic [2:0]                r_o_status, n_o_status;
    logic [108:0]              r_o_data, n_o_data;

    // table ports
    logic              w_geo_we, w_fill_we, w_rd;
    logic [GEO_W-1:0]  w_geo_wdata, w_geo_rdata;
    logic [BW-1:0]     w_fill_wdata, w_fill_rdata;
    cba_pkg::t_fit_res w_fit;

    // scratch
    logic [3:0]                w_alog;
    logic [ALW:0]              w_align;
    logic [CW-1:0]             w_idx_inc;
    logic [cba_pkg::SIZE_W-1:0] w_size_a;
    logic [cba_pkg::WIDE_W-1:0] w_end;
    logic                      w_ok;
    logic [CW+2:0]             w_cidx;

    localparam logic [BW-1:0] TOP_MASK = BW'((64'd1 << cba_pkg::MAX_ALIGN_LOG2) - 64'd1);

    cba_ram #(.WIDTH(GEO_W), .DEPTH(MAX_CHUNKS)) u_geo_ram (
        .i_clk   (i_clk),
        .i_we    (w_geo_we),
        .i_waddr (r_idx[IW-1:0]),
        .i_wdata (w_geo_wdata),
        .i_re    (w_rd),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_geo_rdata)
    );

    cba_ram #(.WIDTH(BW), .DEPTH(MAX_CHUNKS)) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (w_fill_we),
        .i_waddr (r_idx[IW-1:0]),
        .i_wdata (w_fill_wdata),
        .i_re    (w_rd),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_fill_rdata)
    );

    cba_fit u_fit (
        .i_start (w_geo_rdata[cba_pkg::ADDR_W-1:0]),
        .i_fill  (w_fill_rdata),
        .i_bytes (w_geo_rdata[GEO_W-1:cba_pkg::ADDR_W]),
        .i_mask  (r_mask),
        .i_pad   (r_pad),
        .i_req   (r_req),
        .o_res   (w_fit)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = {3'b000, r_o_data};

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & ~m_axis_tready;
        n_open      = r_open;
        n_top       = r_top;
        n_reserved  = r_reserved;
        n_used      = r_used;
        n_peak      = r_peak;
        n_alloc     = r_alloc;
        n_dflt      = i_cfg_we ? i_cfg_wdata : r_dflt;
        n_count     = r_count;
        n_isize     = r_isize;
        n_mask      = r_mask;
        n_req       = r_req;
        n_idx       = r_idx;
        n_pad       = r_pad;
        n_al        = r_al;
        n_base      = r_base;
        n_size      = r_size;
        n_status    = r_status;
        n_addr      = r_addr;
        n_success   = r_success;
        n_o_status  = r_o_status;
        n_o_data    = r_o_data;

        w_geo_we     = 1'b0;
        w_fill_we    = 1'b0;
        w_rd         = 1'b0;
        w_geo_wdata  = {r_size[BW-1:0], r_base[cba_pkg::ADDR_W-1:0]};
        w_fill_wdata = '0;

        w_idx_inc = r_idx + CW'(1);
        w_alog    = s_axis_tdata[35:32];
        if (w_alog < 4'(cba_pkg::MIN_ALIGN_LOG2)) begin
            w_alog = 4'(cba_pkg::MIN_ALIGN_LOG2);
        end else if (w_alog > 4'(cba_pkg::MAX_ALIGN_LOG2)) begin
            w_alog = 4'(cba_pkg::MAX_ALIGN_LOG2);
        end
        w_align  = (ALW + 1)'(1) << w_alog;
        w_size_a = cba_pkg::SIZE_W'(r_req) + cba_pkg::SIZE_W'({1'b0, r_mask})
                   + cba_pkg::SIZE_W'(1);
        w_end    = cba_pkg::WIDE_W'(r_base) + cba_pkg::WIDE_W'(r_size);
        w_ok     = (r_open < CW'(MAX_CHUNKS))
                   && (w_end <= cba_pkg::WIDE_W'(cba_pkg::REGION_BYTES));
        w_cidx   = (CW + 3)'(r_idx);

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_count   = s_axis_tdata[15:0];
                    n_isize   = s_axis_tdata[31:16];
                    n_mask    = ALW'(w_align - (ALW + 1)'(1));
                    n_addr    = '0;
                    n_success = 1'b0;
                    n_idx     = '0;
                    n_status  = cba_pkg::ST_DONE;
                    n_state   = S_RESP;
                    unique case (cba_pkg::t_kind'(s_axis_tuser))
                        cba_pkg::KIND_ALLOC: begin
                            if ((s_axis_tdata[15:0] == 16'd0) || (s_axis_tdata[31:16] == 16'd0)) begin
                                n_status = cba_pkg::ST_ZERO;
                            end else begin
                                n_state = S_MUL;
                            end
                        end
                        cba_pkg::KIND_RESET: begin
                            n_used = '0;
                            if (r_open != '0) begin
                                n_state = S_CLR;
                            end
                        end
                        cba_pkg::KIND_FINAL: begin
                            // release every chunk and clear the statistics
                            n_open     = '0;
                            n_top      = '0;
                            n_reserved = '0;
                            n_used     = '0;
                            n_peak     = '0;
                            n_alloc    = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MUL: begin
                n_req   = cba_pkg::REQ_W'(r_count) * cba_pkg::REQ_W'(r_isize);
                n_state = (r_open == '0) ? S_NEWC : S_RD;
            end
            S_RD: begin
                w_rd    = 1'b1;
                n_state = S_PAD;
            end
            S_PAD: begin
                n_pad   = w_fit.pad;
                n_al    = w_fit.al;
                n_state = S_FIT;
            end
            S_FIT: begin
                if (w_fit.fits) begin
                    // bump this chunk's fill by padding plus request
                    w_fill_we    = 1'b1;
                    w_fill_wdata = w_fit.new_fill[BW-1:0];
                    n_used       = r_used + w_fit.need[BW-1:0];
                    n_status     = cba_pkg::ST_OK_OLD;
                    n_addr       = r_al[cba_pkg::ADDR_W-1:0];
                    n_success    = 1'b1;
                    n_state      = S_STAT;
                end else begin
                    n_idx   = w_idx_inc;
                    n_state = (w_idx_inc == r_open) ? S_NEWC : S_RD;
                end
            end
            S_NEWC: begin
                n_base  = (r_top + TOP_MASK) & ~TOP_MASK;
                n_size  = (cba_pkg::SIZE_W'(r_dflt) > w_size_a)
                          ? cba_pkg::SIZE_W'(r_dflt) : w_size_a;
                n_idx   = r_open;
                n_state = S_NEWF;
            end
            S_NEWF: begin
                if (w_ok) begin
                    w_geo_we     = 1'b1;
                    w_fill_we    = 1'b1;
                    w_fill_wdata = r_req[BW-1:0];
                    n_open       = r_open + CW'(1);
                    n_top        = w_end[BW-1:0];
                    n_reserved   = r_reserved + r_size[BW-1:0];
                    n_used       = r_used + r_req[BW-1:0];
                    n_status     = cba_pkg::ST_OK_NEW;
                    n_addr       = r_base[cba_pkg::ADDR_W-1:0];
                    n_success    = 1'b1;
                    n_state      = S_STAT;
                end else begin
                    n_status = cba_pkg::ST_FULL;
                    n_state  = S_RESP;
                end
            end
            S_STAT: begin
                if (r_alloc != '1) begin
                    n_alloc = r_alloc + cba_pkg::CNT_W'(1);
                end
                if (r_used > r_peak) begin
                    n_peak = r_used;
                end
                n_state = S_RESP;
            end
            S_CLR: begin
                // empty one open chunk a cycle
                w_fill_we = 1'b1;
                n_idx     = w_idx_inc;
                if (w_idx_inc == r_open) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                // hold until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_data    = {r_alloc, r_peak, r_reserved,
                                   r_success ? w_cidx[2:0] : 3'b000, r_addr};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_open      <= '0;
            r_top       <= '0;
            r_reserved  <= '0;
            r_used      <= '0;
            r_peak      <= '0;
            r_alloc     <= '0;
            r_dflt      <= BW'(cba_pkg::RESET_CHUNK_SIZE);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_open      <= n_open;
            r_top       <= n_top;
            r_reserved  <= n_reserved;
            r_used      <= n_used;
            r_peak      <= n_peak;
            r_alloc     <= n_alloc;
            r_dflt      <= n_dflt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count    <= n_count;
        r_isize    <= n_isize;
        r_mask     <= n_mask;
        r_req      <= n_req;
        r_idx      <= n_idx;
        r_pad      <= n_pad;
        r_al       <= n_al;
        r_base     <= n_base;
        r_size     <= n_size;
        r_status   <= n_status;
        r_addr     <= n_addr;
        r_success  <= n_success;
        r_o_status <= n_o_status;
        r_o_data   <= n_o_data;
    end

    `CBA_ASSERT_IMPLY(a_open_bound, i_clk, i_rst_n, 1'b1, r_open <= CW'(MAX_CHUNKS), "open chunk count above slot count")
    `CBA_ASSERT_IMPLY(a_used_in_reserved, i_clk, i_rst_n, 1'b1, r_used <= r_reserved, "used bytes exceed reserved bytes")
    `CBA_ASSERT_IMPLY(a_peak_in_reserved, i_clk, i_rst_n, 1'b1, r_peak <= r_reserved, "peak exceeds reserved bytes")
    `CBA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "item taken while busy")

endmodule

`default_nettype wire

>>> verif/chunked_bump_allocator_checker.sv
module chunked_bump_allocator_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [24:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // count[15:0], elem_bytes[31:16], align_log2[35:32]
    input  logic [1:0]   s_axis_tuser,   // kind[1:0]
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [111:0] m_axis_tdata,   // address[23:0], chunk_index[26:24], total_bytes[51:27],
                                         // peak_bytes[76:52], alloc_total[108:77]
    input  logic [2:0]   m_axis_tuser,   // status[2:0]
    output int unsigned  o_owed,
    output int unsigned  o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        cba_pkg::t_status status;
        logic [23:0]      address;
        logic [2:0]       chunk;
        logic [24:0]      reserved;
        logic [24:0]      peak;
        logic [31:0]      allocs;
    } t_alloc_reply;

    // Shadow arena
    bit [63:0]    seg_base [cba_pkg::DEF_MAX_CHUNKS];
    bit [63:0]    seg_size [cba_pkg::DEF_MAX_CHUNKS];
    bit [63:0]    seg_used [cba_pkg::DEF_MAX_CHUNKS];
    int unsigned  n_open;
    bit [63:0]    top_mark;
    bit [63:0]    reserved;
    bit [63:0]    peak_used;
    bit [31:0]    n_allocs;
    bit [63:0]    min_chunk;

    t_alloc_reply replies_owed[$];
    int unsigned  mismatches;

    function automatic t_alloc_reply apply_request(input cba_pkg::t_kind kind,
                                                   input bit [15:0] cnt,
                                                   input bit [15:0] isz, input bit [3:0] alog);
        t_alloc_reply r;
        bit [63:0]    req;
        bit [63:0]    align;
        bit [63:0]    cur;
        bit [63:0]    aligned;
        bit [63:0]    need;
        bit [63:0]    span;
        bit [63:0]    base;
        bit [63:0]    sum;
        int unsigned  lg;
        bit           placed;
        r.status  = cba_pkg::ST_DONE;
        r.address = '0;
        r.chunk   = '0;
        placed    = 1'b0;
        case (kind)
            cba_pkg::KIND_ALLOC: begin
                req = 64'(cnt) * 64'(isz);
                if (req == 0) begin
                    r.status = cba_pkg::ST_ZERO;
                end else begin
                    lg = alog;
                    if (lg < cba_pkg::MIN_ALIGN_LOG2) lg = cba_pkg::MIN_ALIGN_LOG2;
                    if (lg > cba_pkg::MAX_ALIGN_LOG2) lg = cba_pkg::MAX_ALIGN_LOG2;
                    align = 64'd1 << lg;
                    // first fit over the open chunks, padding included
                    for (int unsigned i = 0; i < n_open && !placed; i++) begin
                        cur     = seg_base[i] + seg_used[i];
                        aligned = (cur + align - 64'd1) & ~(align - 64'd1);
                        need    = (aligned - cur) + req;
                        if (seg_used[i] + need <= seg_size[i]) begin
                            seg_used[i] += need;
                            r.status  = cba_pkg::ST_OK_OLD;
                            r.address = aligned[23:0];
                            r.chunk   = 3'(i);
                            placed    = 1'b1;
                        end
                    end
                    if (!placed) begin
                        span = req + align;
                        if (min_chunk > span) span = min_chunk;
                        base = (top_mark + (64'd1 << cba_pkg::MAX_ALIGN_LOG2) - 64'd1)
                               & ~((64'd1 << cba_pkg::MAX_ALIGN_LOG2) - 64'd1);
                        if (n_open < cba_pkg::DEF_MAX_CHUNKS
                            && base + span <= cba_pkg::REGION_BYTES) begin
                            seg_base[n_open] = base;
                            seg_size[n_open] = span;
                            seg_used[n_open] = req;
                            r.status  = cba_pkg::ST_OK_NEW;
                            r.address = base[23:0];
                            r.chunk   = 3'(n_open);
                            n_open++;
                            top_mark  = base + span;
                            reserved += span;
                            placed    = 1'b1;
                        end else begin
                            r.status = cba_pkg::ST_FULL;
                        end
                    end
                    if (placed) begin
                        if (n_allocs != 32'hFFFF_FFFF) n_allocs++;
                        sum = 0;
                        for (int unsigned i = 0; i < n_open; i++) sum += seg_used[i];
                        if (sum > peak_used) peak_used = sum;
                    end
                end
            end
            cba_pkg::KIND_RESET: begin
                for (int unsigned i = 0; i < n_open; i++) seg_used[i] = 0;
            end
            cba_pkg::KIND_FINAL: begin
                n_open    = 0;
                top_mark  = 0;
                reserved  = 0;
                peak_used = 0;
                n_allocs  = 0;
            end
            default: ;
        endcase
        r.reserved = reserved[24:0];
        r.peak     = peak_used[24:0];
        r.allocs   = n_allocs;
        return r;
    endfunction

    task automatic check_field(input string field, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_alloc_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < cba_pkg::DEF_MAX_CHUNKS; i++) begin
                seg_base[i] = 0;
                seg_size[i] = 0;
                seg_used[i] = 0;
            end
            n_open    = 0;
            top_mark  = 0;
            reserved  = 0;
            peak_used = 0;
            n_allocs  = 0;
            min_chunk = cba_pkg::RESET_CHUNK_SIZE;
            replies_owed.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (replies_owed.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got status %0d",
                             $time, m_axis_tuser);
                end else begin
                    want = replies_owed.pop_front();
                    check_field("status", want.status, m_axis_tuser);
                    check_field("address", want.address, m_axis_tdata[23:0]);
                    check_field("chunk_index", want.chunk, m_axis_tdata[26:24]);
                    check_field("total_bytes", want.reserved, m_axis_tdata[51:27]);
                    check_field("peak_bytes", want.peak, m_axis_tdata[76:52]);
                    check_field("alloc_total", want.allocs, m_axis_tdata[108:77]);
                end
            end
            if (i_cfg_we) min_chunk = 64'(i_cfg_wdata);
            if (s_axis_tvalid && s_axis_tready) begin
                replies_owed.push_back(apply_request(cba_pkg::t_kind'(s_axis_tuser),
                                                     s_axis_tdata[15:0],
                                                     s_axis_tdata[31:16],
                                                     s_axis_tdata[35:32]));
            end
        end
        o_owed       <= replies_owed.size();
        o_mismatches <= mismatches;
    end

    initial mismatches = 0;
endmodule

>>> verif/chunked_bump_allocator_tb.sv
module chunked_bump_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PHASE_ITEMS  = 120;  // random items per chunk-size setting
    localparam int unsigned HOLD_AT      = 300;  // result count at which the sink stalls
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned IDLE_LIMIT   = 4000; // cycles without any handshake
    localparam int unsigned TAIL_CYCLES  = 40;   // lets stray results arrive before the verdict

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [24:0]  i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata = '0;   // count[15:0], elem_bytes[31:16], align_log2[35:32]
    logic [1:0]   s_axis_tuser = '0;   // kind[1:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;        // address[23:0], chunk_index[26:24], total_bytes[51:27],
                                       // peak_bytes[76:52], alloc_total[108:77]
    logic [2:0]   m_axis_tuser;        // status[2:0]

    int unsigned  owed;
    int unsigned  mismatches;
    bit           src_burst = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    chunked_bump_allocator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    chunked_bump_allocator_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_owed        (owed),
        .o_mismatches  (mismatches)
    );

    // Offer one item after a random gap, hold it until the block takes it.
    // With no gap, tvalid stays high straight into the next item.
    task automatic send_request(input cba_pkg::t_kind kind, input bit [15:0] cnt,
                                input bit [15:0] isz, input bit [3:0] alog);
        int unsigned gap;
        gap = src_burst ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, alog, isz, cnt};
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Drop tvalid and hold until every predicted result has come back.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (owed != 0) @(posedge i_clk);
    endtask

    // Write the default chunk size; only called with the block idle.
    task automatic write_chunk_size(input logic [24:0] value);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly allocations of modest size so chunks fill up, first fit gets
    // exercised and the arena runs out; resets and finalizes recycle it.
    task automatic random_request;
        int unsigned    pick;
        int unsigned    shape;
        cba_pkg::t_kind kind;
        bit [15:0]      cnt;
        bit [15:0]      isz;
        pick  = $urandom_range(0, 99);
        shape = $urandom_range(0, 19);
        if (pick < 6)       kind = cba_pkg::KIND_RESET;
        else if (pick < 10) kind = cba_pkg::KIND_FINAL;
        else if (pick < 12) kind = cba_pkg::KIND_NOP;
        else                kind = cba_pkg::KIND_ALLOC;
        cnt = 16'($urandom_range(1, 64));
        isz = 16'($urandom_range(1, 512));
        if (kind != cba_pkg::KIND_ALLOC || shape < 2) begin
            cnt = 16'($urandom);
            isz = 16'($urandom);
        end else if (shape < 4) begin
            cnt = 16'($urandom_range(1, 16));
            isz = 16'($urandom);
        end else if (shape == 4) begin
            // zero-size request, either factor
            if ($urandom_range(0, 1)) cnt = '0;
            else isz = '0;
        end
        send_request(kind, cnt, isz, 4'($urandom_range(0, 15)));
    endtask

    // Stimulus
    initial begin
        logic [24:0] chunk_sizes [6];
        chunk_sizes[0] = 25'd16;
        chunk_sizes[1] = 25'd16777216;
        chunk_sizes[2] = 25'($urandom_range(16, 16777216));
        chunk_sizes[3] = 25'($urandom_range(16, 1024));
        chunk_sizes[4] = 25'($urandom_range(1024, 262144));
        chunk_sizes[5] = 25'd65536;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, default chunk size after reset
        send_request(cba_pkg::KIND_ALLOC, 16'd0, 16'd5, 4'd4);        // zero count
        send_request(cba_pkg::KIND_ALLOC, 16'd7, 16'd0, 4'd4);        // zero element size
        send_request(cba_pkg::KIND_ALLOC, 16'd1, 16'd1, 4'd0);        // opens chunk 0
        send_request(cba_pkg::KIND_ALLOC, 16'd1, 16'd1, 4'd3);        // padded to 16
        send_request(cba_pkg::KIND_ALLOC, 16'd1, 16'd100, 4'd12);     // largest alignment
        send_request(cba_pkg::KIND_ALLOC, 16'd1, 16'd8, 4'd15);       // alignment saturates
        send_request(cba_pkg::KIND_ALLOC, 16'hFFFF, 16'hFFFF, 4'd4);  // larger than the region
        send_request(cba_pkg::KIND_NOP, 16'hFFFF, 16'hFFFF, 4'hF);    // unused kind
        send_request(cba_pkg::KIND_RESET, 16'd0, 16'd0, 4'd0);        // empty chunk 0, keep it
        send_request(cba_pkg::KIND_ALLOC, 16'd1, 16'd16, 4'd4);       // reuses chunk 0
        // each of these overflows the default size, so every one opens a chunk
        repeat (7) send_request(cba_pkg::KIND_ALLOC, 16'd1, 16'hFFFF, 4'd4);
        send_request(cba_pkg::KIND_ALLOC, 16'd1, 16'hFFFF, 4'd4);     // no chunk slot left
        send_request(cba_pkg::KIND_ALLOC, 16'd1, 16'd16, 4'd0);       // still fits in chunk 0
        send_request(cba_pkg::KIND_FINAL, 16'd3, 16'd3, 4'd3);
        send_request(cba_pkg::KIND_ALLOC, 16'd256, 16'd256, 4'd12);
        send_request(cba_pkg::KIND_ALLOC, 16'hFFFF, 16'h00FF, 4'd4);  // region exhausted
        send_request(cba_pkg::KIND_FINAL, 16'hFFFF, 16'hFFFF, 4'hF);
        send_request(cba_pkg::KIND_ALLOC, 16'hFFFF, 16'h0100, 4'd4);  // nearly the whole region
        send_request(cba_pkg::KIND_ALLOC, 16'd1, 16'd1, 4'd4);        // top of the region
        send_request(cba_pkg::KIND_RESET, 16'hFFFF, 16'hFFFF, 4'hF);
        drain();

        // Random part, one phase per chunk size
        foreach (chunk_sizes[p]) begin
            write_chunk_size(chunk_sizes[p]);
            if (p % 2 == 1) send_request(cba_pkg::KIND_FINAL, 16'd0, 16'd0, 4'd0);
            for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) src_burst = ($urandom_range(0, 3) == 0);
                random_request();
            end
            drain();
        end
        src_burst = 1'b0;

        // Let any stray result show up before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (owed != 0)
            $display("%0t: %0d results never arrived", $time, owed);
        if (mismatches == 0 && owed == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Result sink: random stalls per item, bursts of full rate, and one long
    // hold-off so the block backs up and stalls its input.
    initial begin
        int unsigned taken;
        int unsigned stall;
        bit          sink_burst;
        taken      = 0;
        sink_burst = 1'b0;
        forever begin
            if (taken % 30 == 0) sink_burst = ($urandom_range(0, 3) == 0);
            stall = sink_burst ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            taken++;
            if (taken == HOLD_AT) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
        end
    end

    // Watchdog: give up when neither channel moves for too long
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end
endmodule
